// File: rtl/core/biq_pkg.sv
`default_nettype none

package biq_pkg;

   localparam int COEF_WIDTH    = 20;
   localparam int ACC_WIDTH     = 40;
   localparam int NUM_COEF      = 5;
   localparam int CSR_IDX_WIDTH = 3;

   localparam logic signed [COEF_WIDTH-1:0] COEF_B0_RESET = 20'sd65536;

   typedef enum logic [2:0] {
      COEF_B0 = 3'd0,
      COEF_B1 = 3'd1,
      COEF_B2 = 3'd2,
      COEF_A1 = 3'd3,
      COEF_A2 = 3'd4
   } coef_sel_type;

   typedef enum logic [1:0] {
      BASE_HOLD,
      BASE_D1,
      BASE_D2,
      BASE_ACC
   } acc_base_type;

   typedef enum logic [1:0] {
      D1_HOLD,
      D1_CLAMP,
      D1_ZERO
   } d1_op_type;

   typedef enum logic [1:0] {
      D2_HOLD,
      D2_LOAD_P,
      D2_CLAMP,
      D2_ZERO
   } d2_op_type;

   typedef enum logic [1:0] {
      JC_NONE,
      JC_CLEAR,
      JC_ALWAYS
   } jmp_type;

   typedef enum logic [2:0] {
      ST_B0X,
      ST_B1X,
      ST_B2X,
      ST_A1Y,
      ST_A2Y,
      ST_D1,
      ST_D2,
      ST_CLEAR
   } step_type;

   typedef struct packed {
      logic         mul_en;
      coef_sel_type coef_sel;
      logic         mul_y;
      acc_base_type acc_base;
      logic         acc_sub;
      logic         y_wr;
      d1_op_type    d1_op;
      d2_op_type    d2_op;
      jmp_type      jmp;
      step_type     target;
      logic         last;
   } ctl_type;

   localparam ctl_type CTL_NOP = '{
      mul_en:   1'b0,
      coef_sel: COEF_B0,
      mul_y:    1'b0,
      acc_base: BASE_HOLD,
      acc_sub:  1'b0,
      y_wr:     1'b0,
      d1_op:    D1_HOLD,
      d2_op:    D2_HOLD,
      jmp:      JC_NONE,
      target:   ST_B0X,
      last:     1'b0
   };

   // The product register loads only on multiplier steps, so each
   // accumulate uses the product that the last multiplying step started.
   function automatic ctl_type prog_word(input step_type step);
      ctl_type w;
      w = CTL_NOP;
      unique case (step)
         ST_B0X: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_B0;
            w.jmp      = JC_CLEAR;
            w.target   = ST_CLEAR;
         end
         ST_B1X: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_B1;
            w.acc_base = BASE_D1;
         end
         ST_B2X: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_B2;
            w.acc_base = BASE_D2;
            w.y_wr     = 1'b1;
         end
         ST_A1Y: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_A1;
            w.mul_y    = 1'b1;
            w.d2_op    = D2_LOAD_P;
         end
         ST_A2Y: begin
            w.mul_en   = 1'b1;
            w.coef_sel = COEF_A2;
            w.mul_y    = 1'b1;
            w.acc_base = BASE_ACC;
            w.acc_sub  = 1'b1;
         end
         ST_D1: begin
            w.acc_base = BASE_D2;
            w.acc_sub  = 1'b1;
            w.d1_op    = D1_CLAMP;
         end
         ST_D2: begin
            w.d2_op = D2_CLAMP;
            w.last  = 1'b1;
         end
         ST_CLEAR: begin
            w.d1_op  = D1_ZERO;
            w.d2_op  = D2_ZERO;
            w.jmp    = JC_ALWAYS;
            w.target = ST_B1X;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/biq_if.sv
`default_nettype none

interface biq_req_if #(parameter int SAMPLE_WIDTH = 16) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;
   logic                           clear_history;

   modport source (output valid, sample_in, clear_history, input ready);
   modport sink (input valid, sample_in, clear_history, output ready);
endinterface

interface biq_rsp_if #(parameter int SAMPLE_WIDTH = 16) ();
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   logic                           saturated;

   modport source (output valid, sample_out, saturated, input ready);
   modport sink (input valid, sample_out, saturated, output ready);
endinterface

interface biq_csr_if import biq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [CSR_IDX_WIDTH-1:0]     index;
   logic signed [COEF_WIDTH-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/biq_dp.sv
`default_nettype none

module biq_dp import biq_pkg::*; #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           x_load,
   input  logic signed [SAMPLE_WIDTH-1:0] x_sample,
   input  logic                           csr_wr,
   input  logic [CSR_IDX_WIDTH-1:0]       csr_idx,
   input  logic signed [COEF_WIDTH-1:0]   csr_data,
   input  ctl_type                        ctl,
   output logic signed [SAMPLE_WIDTH-1:0] y_out,
   output logic                           sat_out
);

   localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int HOLD_W = (PROD_W > ACC_WIDTH) ? PROD_W : ACC_WIDTH;
   localparam int SUM_W  = HOLD_W + 2;

   localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [SUM_W-1:0] Y_MAX    = (SUM_W'(1) <<< (SAMPLE_WIDTH - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] Y_MIN    = ~Y_MAX;
   localparam logic signed [SUM_W-1:0] ACC_MAX  = (SUM_W'(1) <<< (ACC_WIDTH - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] ACC_MIN  = ~ACC_MAX;

   logic signed [COEF_WIDTH-1:0]   coef_ff [NUM_COEF];
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [SAMPLE_WIDTH-1:0] y_ff, y_in;
   logic                           sat_ff, sat_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [SUM_W-1:0]        acc_ff, acc_in;
   logic signed [ACC_WIDTH-1:0]    d1_ff, d1_in;
   logic signed [HOLD_W-1:0]       d2_ff, d2_in;

   logic signed [COEF_WIDTH-1:0]   mul_a;
   logic signed [SAMPLE_WIDTH-1:0] mul_b;
   logic signed [SUM_W-1:0]        base;
   logic signed [SUM_W-1:0]        rnd_sum;
   logic signed [SUM_W-1:0]        y_wide;
   logic signed [ACC_WIDTH-1:0]    acc_clamped;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0] <= COEF_B0_RESET;
         for (int i = 1; i < NUM_COEF; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_wr && (csr_idx < CSR_IDX_WIDTH'(NUM_COEF))) begin
         coef_ff[csr_idx] <= csr_data;
      end
   end

   assign mul_a   = coef_ff[ctl.coef_sel];
   assign mul_b   = ctl.mul_y ? y_ff : x_ff;
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_comb begin
      base = '0;
      case (ctl.acc_base)
         BASE_D1:  base = SUM_W'(d1_ff);
         BASE_D2:  base = SUM_W'(d2_ff);
         BASE_ACC: base = acc_ff;
         default:  base = '0;
      endcase
      if (ctl.acc_sub) begin
         acc_in = base - SUM_W'(prod_ff);
      end else begin
         acc_in = base + SUM_W'(prod_ff);
      end
   end

   always_comb begin
      rnd_sum = acc_ff + RND_HALF;
      y_wide  = rnd_sum >>> COEF_FRAC_BITS;
      if (y_wide > Y_MAX) begin
         y_in   = Y_MAX[SAMPLE_WIDTH-1:0];
         sat_in = 1'b1;
      end else if (y_wide < Y_MIN) begin
         y_in   = Y_MIN[SAMPLE_WIDTH-1:0];
         sat_in = 1'b1;
      end else begin
         y_in   = y_wide[SAMPLE_WIDTH-1:0];
         sat_in = 1'b0;
      end
   end

   always_comb begin
      if (acc_ff > ACC_MAX) begin
         acc_clamped = ACC_MAX[ACC_WIDTH-1:0];
      end else if (acc_ff < ACC_MIN) begin
         acc_clamped = ACC_MIN[ACC_WIDTH-1:0];
      end else begin
         acc_clamped = acc_ff[ACC_WIDTH-1:0];
      end
   end

   always_comb begin
      d1_in = d1_ff;
      case (ctl.d1_op)
         D1_CLAMP: d1_in = acc_clamped;
         D1_ZERO:  d1_in = '0;
         default:  d1_in = d1_ff;
      endcase
      d2_in = d2_ff;
      case (ctl.d2_op)
         D2_LOAD_P: d2_in = HOLD_W'(prod_ff);
         D2_CLAMP:  d2_in = HOLD_W'(acc_clamped);
         D2_ZERO:   d2_in = '0;
         default:   d2_in = d2_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else begin
         d1_ff <= d1_in;
         d2_ff <= d2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (x_load) begin
         x_ff <= x_sample;
      end
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.acc_base != BASE_HOLD) begin
         acc_ff <= acc_in;
      end
      if (ctl.y_wr) begin
         y_ff   <= y_in;
         sat_ff <= sat_in;
      end
   end

   assign y_out   = y_ff;
   assign sat_out = sat_ff;

endmodule

`default_nettype wire

// File: rtl/core/biq_seq.sv
`default_nettype none

module biq_seq import biq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    clear_req,
   input  logic    out_free,
   output ctl_type ctl,
   output logic    busy,
   output logic    done
);

   logic     busy_ff, busy_in;
   step_type step_ff, step_in;
   logic     clr_ff, clr_in;
   ctl_type  word;
   logic     hold;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= ST_B0X;
         clr_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         clr_ff  <= clr_in;
      end
   end

   always_comb begin
      word    = prog_word(step_ff);
      hold    = word.last && !out_free;
      ctl     = (busy_ff && !hold) ? word : CTL_NOP;
      done    = busy_ff && word.last && out_free;
      busy_in = busy_ff;
      step_in = step_ff;
      clr_in  = clr_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = ST_B0X;
            clr_in  = clear_req;
         end
      end else if (!hold) begin
         if (word.last) begin
            busy_in = 1'b0;
         end
         unique case (word.jmp)
            JC_ALWAYS: step_in = word.target;
            JC_CLEAR:  step_in = clr_ff ? word.target : step_type'(3'(step_ff + 3'd1));
            JC_NONE:   step_in = step_type'(3'(step_ff + 3'd1));
            default:   step_in = step_ff;
         endcase
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// File: rtl/core/biquad_iir_section.sv
`default_nettype none

// Channel   Port      Direction  Payload
// input     req_chan  sink       sample_in, clear_history
// result    rsp_chan  source     sample_out, saturated
// config    csr_chan  sink       index, data (coefficient registers 0 to 4)
//
// A word is taken when the sequencer is idle and is worked through seven steps of the
// control program on one shared multiplier, with a clear step added when clear_history
// is set; no new word is taken until the last one is through.
// The result sits in an output register; the last step waits while that register
// still holds a word not yet taken.
// Reset loads the coefficient defaults, zeroes both delay accumulators and holds
// both ready lines low.

module biquad_iir_section import biq_pkg::*; #(
   parameter int SAMPLE_WIDTH   = 16,
   parameter int COEF_FRAC_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   biq_req_if.sink    req_chan,
   biq_rsp_if.source  rsp_chan,
   biq_csr_if.sink    csr_chan
);

   ctl_type                        ctl;
   logic                           busy;
   logic                           done;
   logic                           start;
   logic                           out_free;
   logic signed [SAMPLE_WIDTH-1:0] y;
   logic                           sat;

   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic                           rsp_sat_ff;

   assign req_chan.ready = !busy && !reset;
   assign start          = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = !reset;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   biq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .clear_req (req_chan.clear_history),
      .out_free  (out_free),
      .ctl       (ctl),
      .busy      (busy),
      .done      (done)
   );

   biq_dp #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .x_load   (start),
      .x_sample (req_chan.sample_in),
      .csr_wr   (csr_chan.valid && csr_chan.ready),
      .csr_idx  (csr_chan.index),
      .csr_data (csr_chan.data),
      .ctl      (ctl),
      .y_out    (y),
      .sat_out  (sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_sample_ff <= y;
         rsp_sat_ff    <= sat;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_sample_ff;
   assign rsp_chan.saturated  = rsp_sat_ff;

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      start |=> busy)
      else $error("sequencer did not start on an accepted word");

   a_rsp_from_work : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy))
      else $error("result appeared without a word in progress");

   a_sat_bound : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sat_ff) |->
         (rsp_sample_ff == {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}) ||
         (rsp_sample_ff == {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}))
      else $error("saturated result is not at a range bound");

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top import biq_pkg::*; ();

   localparam int SAMPLE_WIDTH   = 16;
   localparam int COEF_FRAC_BITS = 16;
   localparam int RAND_PHASES    = 10;
   localparam int PHASE_WORDS    = 115;
   localparam int SETTLE_CYCLES  = 12;

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [COEF_WIDTH-1:0]   COEF_MAX   = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   localparam logic signed [COEF_WIDTH-1:0]   COEF_MIN   = {1'b1, {(COEF_WIDTH-1){1'b0}}};
   localparam logic signed [COEF_WIDTH-1:0]   COEF_UNITY = COEF_B0_RESET;
   localparam logic signed [COEF_WIDTH-1:0]   COEF_HALF  = COEF_B0_RESET >>> 1;
   localparam longint HALF_LSB = longint'(1) <<< (COEF_FRAC_BITS - 1);

   typedef struct {
      logic signed [SAMPLE_WIDTH-1:0] sample_out;
      logic                           saturated;
   } filtered_word_type;

   class biquad_tracker;
      logic signed [COEF_WIDTH-1:0] coef [NUM_COEF];
      logic signed [ACC_WIDTH-1:0]  delay_one;
      logic signed [ACC_WIDTH-1:0]  delay_two;
      filtered_word_type            pending_outputs [$];
      int                           errors;
      int                           results_seen;

      function new();
         coef[COEF_B0] = COEF_B0_RESET;
         coef[COEF_B1] = '0;
         coef[COEF_B2] = '0;
         coef[COEF_A1] = '0;
         coef[COEF_A2] = '0;
         delay_one     = '0;
         delay_two     = '0;
         errors        = 0;
         results_seen  = 0;
      endfunction

      function void write_coef(logic [CSR_IDX_WIDTH-1:0] idx, logic signed [COEF_WIDTH-1:0] val);
         if (idx < NUM_COEF) coef[idx] = val;
      endfunction

      function logic signed [ACC_WIDTH-1:0] clamp_acc(longint v);
         longint hi;
         hi = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
         if (v > hi) return ACC_WIDTH'(hi);
         if (v < -hi - 1) return ACC_WIDTH'(-hi - 1);
         return ACC_WIDTH'(v);
      endfunction

      function void note_sample(logic signed [SAMPLE_WIDTH-1:0] x_in, logic clear);
         longint            x;
         longint            acc;
         longint            y;
         filtered_word_type w;
         x = x_in;
         if (clear) begin
            delay_one = '0;
            delay_two = '0;
         end
         acc = longint'(coef[COEF_B0]) * x + longint'(delay_one);
         y = (acc + HALF_LSB) >>> COEF_FRAC_BITS;
         w.saturated = 1'b0;
         if (y > longint'(SAMPLE_MAX)) begin
            y = SAMPLE_MAX;
            w.saturated = 1'b1;
         end else if (y < longint'(SAMPLE_MIN)) begin
            y = SAMPLE_MIN;
            w.saturated = 1'b1;
         end
         w.sample_out = y[SAMPLE_WIDTH-1:0];
         // The feedback terms use the saturated output.
         delay_one = clamp_acc(longint'(coef[COEF_B1]) * x - longint'(coef[COEF_A1]) * y
                               + longint'(delay_two));
         delay_two = clamp_acc(longint'(coef[COEF_B2]) * x - longint'(coef[COEF_A2]) * y);
         pending_outputs.push_back(w);
      endfunction

      task report(string msg);
         $display("ERROR: %s", msg);
         errors++;
      endtask

      task check_output(logic signed [SAMPLE_WIDTH-1:0] got, logic got_sat);
         filtered_word_type w;
         results_seen++;
         if (pending_outputs.size() == 0) begin
            report($sformatf("word %0d arrived with nothing expected", results_seen));
            return;
         end
         w = pending_outputs.pop_front();
         if (got !== w.sample_out)
            report($sformatf("word %0d sample_out %0d, expected %0d",
                             results_seen, got, w.sample_out));
         if (got_sat !== w.saturated)
            report($sformatf("word %0d saturated %b, expected %b",
                             results_seen, got_sat, w.saturated));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   biq_req_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) req_chan ();
   biq_rsp_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) rsp_chan ();
   biq_csr_if csr_chan ();

   biquad_iir_section #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   biquad_tracker tracker = new();
   bit            req_calm;
   bit            rsp_calm;

   always #10 clock = ~clock;

   function automatic int next_gap(inout bit calm);
      if ($urandom_range(0, 31) == 0) calm = !calm;
      return calm ? 0 : int'($urandom_range(0, 9));
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] draw_sample();
      case ($urandom_range(0, 7))
         0: return ($urandom_range(0, 1) == 0) ? SAMPLE_MAX : SAMPLE_MIN;
         1, 2: return SAMPLE_WIDTH'(int'($urandom_range(0, 512)) - 256);
         default: return SAMPLE_WIDTH'($urandom_range(0, (1 << SAMPLE_WIDTH) - 1));
      endcase
   endfunction

   function automatic logic signed [COEF_WIDTH-1:0] any_coef();
      return COEF_WIDTH'($urandom_range(0, (1 << COEF_WIDTH) - 1));
   endfunction

   function automatic logic signed [COEF_WIDTH-1:0] near_coef(int span);
      return COEF_WIDTH'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   function automatic logic signed [COEF_WIDTH-1:0] corner_coef();
      case ($urandom_range(0, 4))
         0: return COEF_MAX;
         1: return COEF_MIN;
         2: return COEF_UNITY;
         3: return -COEF_UNITY;
         default: return '0;
      endcase
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] s, input logic clr);
      int gap;
      gap = next_gap(req_calm);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.sample_in     <= s;
      req_chan.clear_history <= clr;
      do @(posedge clock); while (!req_chan.ready);
      tracker.note_sample(s, clr);
   endtask

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic signed [COEF_WIDTH-1:0] val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      tracker.write_coef(idx, val);
   endtask

   // Wait until every word sent has come back, then let the design settle.
   task automatic wait_idle();
      while (tracker.pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_coefs(input logic signed [COEF_WIDTH-1:0] b0, b1, b2, a1, a2);
      wait_idle();
      write_reg(COEF_B0, b0);
      write_reg(COEF_B1, b1);
      write_reg(COEF_B2, b2);
      write_reg(COEF_A1, a1);
      write_reg(COEF_A2, a2);
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         int gap;
         gap = next_gap(rsp_calm);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         tracker.check_output(rsp_chan.sample_out, rsp_chan.saturated);
      end
   end

   initial begin
      logic signed [COEF_WIDTH-1:0] a2;
      req_chan.valid         <= 1'b0;
      req_chan.sample_in     <= '0;
      req_chan.clear_history <= 1'b0;
      csr_chan.valid         <= 1'b0;
      csr_chan.index         <= COEF_B0;
      csr_chan.data          <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample('0, 1'b1);
      send_sample(16'sd1, 1'b0);
      send_sample(-16'sd1, 1'b0);
      req_chan.valid <= 1'b0;

      load_coefs(COEF_MAX, '0, '0, '0, '0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(16'sd4096, 1'b0);
      send_sample(-16'sd4096, 1'b0);
      req_chan.valid <= 1'b0;

      load_coefs(COEF_MIN, '0, '0, '0, '0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(16'sd4096, 1'b0);
      req_chan.valid <= 1'b0;

      // Half-unit gain puts odd inputs exactly on a rounding tie.
      load_coefs(COEF_HALF, '0, '0, '0, '0);
      send_sample(16'sd1, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd3, 1'b0);
      send_sample(-16'sd3, 1'b0);
      req_chan.valid <= 1'b0;

      load_coefs(COEF_UNITY, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MIN);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample(16'sd1000, 1'b0);
      req_chan.valid <= 1'b0;

      // Writes beyond the last coefficient must leave every coefficient alone.
      wait_idle();
      for (int k = NUM_COEF; k < (1 << CSR_IDX_WIDTH); k++)
         write_reg(CSR_IDX_WIDTH'(k), COEF_HALF);
      csr_chan.valid <= 1'b0;
      send_sample(16'sd1000, 1'b1);
      send_sample(-16'sd1000, 1'b0);
      req_chan.valid <= 1'b0;

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph % 4)
            0: load_coefs(any_coef(), any_coef(), any_coef(), any_coef(), any_coef());
            1: load_coefs(corner_coef(), corner_coef(), corner_coef(), corner_coef(),
                          corner_coef());
            2: begin
               a2 = near_coef(60000);
               load_coefs(near_coef(40000), near_coef(40000), near_coef(40000),
                          near_coef(65536 + int'(a2) - 2000), a2);
            end
            default: load_coefs(any_coef(), '0, '0, '0, '0);
         endcase
         for (int n = 0; n < PHASE_WORDS; n++)
            send_sample(draw_sample(), $urandom_range(0, 15) == 0);
         req_chan.valid <= 1'b0;
      end

      wait_idle();
      if (tracker.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: files.f
rtl/core/biq_pkg.sv
rtl/core/biq_if.sv
rtl/core/biq_dp.sv
rtl/core/biq_seq.sv
rtl/core/biquad_iir_section.sv
dv/tb_top.sv
